// ===== rtl/ngp_pkg.sv =====
`timescale 1ns / 1ps

package ngp_pkg;

   localparam logic [31:0] LAT_LIMIT = 32'd843314856;
   localparam logic [31:0] LON_LIMIT = 32'd1686629713;
   localparam logic [63:0] ONE_Q60   = 64'h1000_0000_0000_0000;

   localparam logic [127:0] E10    = 128'd10000000000;
   localparam logic [127:0] E13    = 128'd10000000000000;
   localparam logic [127:0] FIVE20 = 128'd95367431640625;

   // series coefficients in Q60
   localparam logic [127:0] C1_W = (128'd52790414 << 60) / E10;
   localparam logic [127:0] C2_W = (128'd232718 << 60) / E10;
   localparam logic [127:0] C3_W = (128'd1262 << 60) / E10;
   localparam logic [127:0] C4_W = (128'd7 << 60) / E10;
   localparam logic [127:0] GA_W = (128'd7803267715 << 60) / E10;
   localparam logic [63:0]  C1   = C1_W[63:0];
   localparam logic [63:0]  C2   = C2_W[63:0];
   localparam logic [63:0]  C3   = C3_W[63:0];
   localparam logic [63:0]  C4   = C4_W[63:0];
   localparam logic [63:0]  GA   = (64'd9 << 60) + GA_W[63:0];

   // height terms: per-mm linear coefficients in Q90, quadratic in Q124
   localparam logic [127:0] K_LIN_W = (128'd30877 << 90) / E13;
   localparam logic [127:0] K_LAT_W = (128'd43 << 90) / E13;
   localparam logic [127:0] QC_W    = (128'd72 << 104) / FIVE20;
   localparam logic [63:0]  K_LIN   = K_LIN_W[63:0];
   localparam logic [63:0]  K_LAT   = K_LAT_W[63:0];
   localparam logic [63:0]  QC      = QC_W[63:0];

   // Taylor terms of the sine: divisors (2k)(2k+1) and floor(2^64 / d)
   localparam int unsigned NUM_TERMS  = 9;
   localparam int unsigned TERM_IDX_W = 4;
   localparam logic [64:0] TWO64 = {1'b1, 64'b0};
   localparam logic [8:0] DIV_D [NUM_TERMS] = '{
      9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342};
   localparam logic [64:0] DIV_RECIP [NUM_TERMS] = '{
      TWO64 / 65'd6,   TWO64 / 65'd20,  TWO64 / 65'd42,
      TWO64 / 65'd72,  TWO64 / 65'd110, TWO64 / 65'd156,
      TWO64 / 65'd210, TWO64 / 65'd272, TWO64 / 65'd342};

   typedef enum logic [4:0] {
      OP_SQUARE_X,
      OP_TERM_MUL,
      OP_TERM_DIV,
      OP_SIN_SQ,
      OP_SIN_4,
      OP_SIN_6,
      OP_SIN_8,
      OP_POLY_1,
      OP_POLY_2,
      OP_POLY_3,
      OP_POLY_4,
      OP_SURFACE,
      OP_KCOEF,
      OP_LINEAR,
      OP_HEIGHT_SQ,
      OP_QUAD
   } ngp_op_type;

   localparam int unsigned NUM_CELLS  = 32;
   localparam int unsigned PIPE_DEPTH = 1 + 3 * NUM_CELLS;
   localparam int unsigned FLIGHT_W   = $clog2(PIPE_DEPTH + 1);

   localparam ngp_op_type CELL_OPS [NUM_CELLS] = '{
      OP_SQUARE_X,
      OP_TERM_MUL, OP_TERM_DIV, OP_TERM_MUL, OP_TERM_DIV, OP_TERM_MUL, OP_TERM_DIV,
      OP_TERM_MUL, OP_TERM_DIV, OP_TERM_MUL, OP_TERM_DIV, OP_TERM_MUL, OP_TERM_DIV,
      OP_TERM_MUL, OP_TERM_DIV, OP_TERM_MUL, OP_TERM_DIV, OP_TERM_MUL, OP_TERM_DIV,
      OP_SIN_SQ, OP_SIN_4, OP_SIN_6, OP_SIN_8,
      OP_POLY_1, OP_POLY_2, OP_POLY_3, OP_POLY_4,
      OP_SURFACE, OP_KCOEF, OP_LINEAR, OP_HEIGHT_SQ, OP_QUAD};

   localparam logic [TERM_IDX_W-1:0] CELL_TERM [NUM_CELLS] = '{
      4'd0,
      4'd0, 4'd0, 4'd1, 4'd1, 4'd2, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
      4'd5, 4'd5, 4'd6, 4'd6, 4'd7, 4'd7, 4'd8, 4'd8,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
      4'd0, 4'd0, 4'd0, 4'd0, 4'd0};

   typedef struct packed {
      logic        err;
      logic        h_neg;
      logic [27:0] h_mag;
      logic [63:0] xx;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] tmp;
      logic [63:0] s2;
      logic [63:0] s4;
      logic [63:0] s6;
      logic [63:0] s8;
      logic [63:0] poly;
      logic [63:0] surf;
      logic [63:0] kcoef;
      logic [63:0] lin;
      logic [63:0] hh;
      logic [43:0] grav;
   } ngp_data_type;

endpackage

// ===== rtl/ngp_if.sv =====
`timescale 1ns / 1ps

interface ngp_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] latitude;
   logic signed [31:0] longitude;
   logic signed [27:0] height_mm;

   modport source (output valid, latitude, longitude, height_mm, input ready);
   modport sink   (input valid, latitude, longitude, height_mm, output ready);
endinterface

interface ngp_rsp_if;
   logic        valid;
   logic        ready;
   logic [43:0] gravity;
   logic        range_error;

   modport source (output valid, gravity, range_error, input ready);
   modport sink   (input valid, gravity, range_error, output ready);
endinterface

// ===== rtl/normal_gravity_from_position_unit.sv =====
`timescale 1ns / 1ps
// Pipeline: one input stage, then 32 three-stage multiply cells in a row.
// Throughput: one transaction per cycle while the response side is ready;
// each cell holds one 64x64 product split into four 32x32 partial products,
// and a stage loads whenever it is empty or its contents move on.
// Reset clears the stage valid flags and the in-flight count only; no warm-up is needed.

module normal_gravity_from_position_unit (
   input logic      clock,
   input logic      reset,
   ngp_req_if.sink  req_chan,
   ngp_rsp_if.source rsp_chan
);
   import ngp_pkg::*;

   logic         prep_valid_ff, prep_ready;
   ngp_data_type prep_data_ff, prep_data_in;
   logic [31:0]  lat_bits, lon_bits, lat_mag, lon_mag;
   logic [27:0]  h_bits;

   logic         chain_valid [NUM_CELLS+1];
   logic         chain_ready [NUM_CELLS+1];
   ngp_data_type chain_data  [NUM_CELLS+1];

   logic [FLIGHT_W-1:0] in_flight_ff, in_flight_in;
   logic req_fire, rsp_fire;

   // input stage: magnitudes, range check, seed of the sine series
   assign lat_bits = $unsigned(req_chan.latitude);
   assign lon_bits = $unsigned(req_chan.longitude);
   assign h_bits   = $unsigned(req_chan.height_mm);
   assign lat_mag  = lat_bits[31] ? 32'd0 - lat_bits : lat_bits;
   assign lon_mag  = lon_bits[31] ? 32'd0 - lon_bits : lon_bits;

   always_comb begin
      prep_data_in       = '0;
      prep_data_in.err   = (lat_mag > LAT_LIMIT) || (lon_mag > LON_LIMIT);
      prep_data_in.h_neg = h_bits[27];
      prep_data_in.h_mag = h_bits[27] ? 28'd0 - h_bits : h_bits;
      prep_data_in.term  = {1'b0, lat_mag, 31'b0};
      prep_data_in.acc   = {1'b0, lat_mag, 31'b0};
      prep_data_in.poly  = ONE_Q60;
   end

   assign prep_ready     = !prep_valid_ff || chain_ready[0];
   assign req_chan.ready = prep_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_valid_ff <= 1'b0;
      end else if (prep_ready) begin
         prep_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (prep_ready) prep_data_ff <= prep_data_in;
   end

   assign chain_valid[0] = prep_valid_ff;
   assign chain_data[0]  = prep_data_ff;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      ngp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (CELL_OPS[i]),
         .term_idx  (CELL_TERM[i]),
         .in_valid  (chain_valid[i]),
         .in_ready  (chain_ready[i]),
         .in_data   (chain_data[i]),
         .out_valid (chain_valid[i+1]),
         .out_ready (chain_ready[i+1]),
         .out_data  (chain_data[i+1])
      );
   end

   assign chain_ready[NUM_CELLS] = rsp_chan.ready;
   assign rsp_chan.valid         = chain_valid[NUM_CELLS];
   assign rsp_chan.gravity       = chain_data[NUM_CELLS].grav;
   assign rsp_chan.range_error   = chain_data[NUM_CELLS].err;

   // transactions in flight, for checking only
   assign req_fire     = req_chan.valid && req_chan.ready;
   assign rsp_fire     = rsp_chan.valid && rsp_chan.ready;
   assign in_flight_in = in_flight_ff + FLIGHT_W'(req_fire) - FLIGHT_W'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.range_error |-> rsp_chan.gravity == 44'd0)
      else $error("range error response carries non-zero gravity");

   a_flight_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= FLIGHT_W'(PIPE_DEPTH))
      else $error("more transactions in flight than pipeline stages");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> in_flight_ff != '0)
      else $error("response offered with no transaction in flight");

endmodule

// ===== rtl/ngp_cell.sv =====
`timescale 1ns / 1ps

module ngp_cell (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ngp_pkg::ngp_op_type                    op,
   input  logic [ngp_pkg::TERM_IDX_W-1:0]         term_idx,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  ngp_pkg::ngp_data_type                  in_data,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output ngp_pkg::ngp_data_type                  out_data
);
   import ngp_pkg::*;

   logic         v1_ff, v2_ff, v3_ff;
   logic         rdy1, rdy2, rdy3;
   logic [63:0]  op_a, op_b, s_clamp;
   logic [63:0]  p00_in, p01_in, p10_in, p11_in;
   logic [63:0]  p00_ff, p01_ff, p10_ff, p11_ff;
   ngp_data_type data1_ff, data2_ff, data3_ff, data3_in;
   logic [127:0] full, shifted;
   logic [6:0]   sh;
   logic [63:0]  prod_in, prod_ff;
   logic [63:0]  qd, rem, q_fix, g_sum, g_rnd;
   logic [8:0]   div_d;

   // stage handshake: a stage loads when it is empty or its contents move on
   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign out_valid = v3_ff;
   assign out_data  = data3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // stage 1: operand selection and 32x32 partial products
   assign s_clamp = (in_data.acc > ONE_Q60) ? ONE_Q60 : in_data.acc;

   always_comb begin
      op_a = in_data.term;
      op_b = in_data.term;
      unique case (op)
         OP_SQUARE_X:  begin op_a = in_data.term;  op_b = in_data.term; end
         OP_TERM_MUL:  begin op_a = in_data.term;  op_b = in_data.xx; end
         OP_TERM_DIV:  begin op_a = in_data.tmp;   op_b = DIV_RECIP[term_idx][63:0]; end
         OP_SIN_SQ:    begin op_a = s_clamp;       op_b = s_clamp; end
         OP_SIN_4:     begin op_a = in_data.s2;    op_b = in_data.s2; end
         OP_SIN_6:     begin op_a = in_data.s2;    op_b = in_data.s4; end
         OP_SIN_8:     begin op_a = in_data.s4;    op_b = in_data.s4; end
         OP_POLY_1:    begin op_a = C1;            op_b = in_data.s2; end
         OP_POLY_2:    begin op_a = C2;            op_b = in_data.s4; end
         OP_POLY_3:    begin op_a = C3;            op_b = in_data.s6; end
         OP_POLY_4:    begin op_a = C4;            op_b = in_data.s8; end
         OP_SURFACE:   begin op_a = GA;            op_b = in_data.poly; end
         OP_KCOEF:     begin op_a = K_LAT;         op_b = in_data.s2; end
         OP_LINEAR:    begin op_a = in_data.kcoef; op_b = {36'b0, in_data.h_mag}; end
         OP_HEIGHT_SQ: begin
            op_a = {36'b0, in_data.h_mag};
            op_b = {36'b0, in_data.h_mag};
         end
         OP_QUAD:      begin op_a = in_data.hh;    op_b = QC; end
         default:      begin op_a = in_data.term;  op_b = in_data.term; end
      endcase
   end

   assign p00_in = op_a[31:0]  * op_b[31:0];
   assign p01_in = op_a[31:0]  * op_b[63:32];
   assign p10_in = op_a[63:32] * op_b[31:0];
   assign p11_in = op_a[63:32] * op_b[63:32];

   always_ff @(posedge clock) begin
      if (rdy1) begin
         p00_ff   <= p00_in;
         p01_ff   <= p01_in;
         p10_ff   <= p10_in;
         p11_ff   <= p11_in;
         data1_ff <= in_data;
      end
   end

   // stage 2: full 128-bit product, shifted right by the amount each operation selects
   always_comb begin
      case (op) inside
         OP_TERM_DIV, OP_QUAD: sh = 7'd64;
         OP_LINEAR:            sh = 7'd30;
         OP_HEIGHT_SQ:         sh = 7'd0;
         default:              sh = 7'd60;
      endcase
   end

   assign full = {p11_ff, 64'b0} + {32'b0, p01_ff, 32'b0} + {32'b0, p10_ff, 32'b0}
               + {64'b0, p00_ff};
   assign shifted = full >> sh;
   assign prod_in = shifted[63:0];

   always_ff @(posedge clock) begin
      if (rdy2) begin
         prod_ff  <= prod_in;
         data2_ff <= data1_ff;
      end
   end

   // stage 3: fold the product into the transaction's working values
   assign div_d = DIV_D[term_idx];
   assign qd    = prod_ff * {55'b0, div_d};
   assign rem   = data2_ff.tmp - qd;
   // reciprocal estimate is at most one short
   assign q_fix = (rem >= {55'b0, div_d}) ? prod_ff + 64'd1 : prod_ff;
   assign g_sum = (data2_ff.h_neg ? data2_ff.surf + data2_ff.lin
                                  : data2_ff.surf - data2_ff.lin) + prod_ff;
   assign g_rnd = (g_sum + 64'h8_0000) >> 20;

   always_comb begin
      data3_in = data2_ff;
      unique case (op) inside
         OP_SQUARE_X:  data3_in.xx  = prod_ff;
         OP_TERM_MUL:  data3_in.tmp = prod_ff;
         OP_TERM_DIV:  begin
            data3_in.term = q_fix;
            // odd powers alternate: the first, third, ... terms subtract
            data3_in.acc  = term_idx[0] ? data2_ff.acc + q_fix : data2_ff.acc - q_fix;
         end
         OP_SIN_SQ:    data3_in.s2 = prod_ff;
         OP_SIN_4:     data3_in.s4 = prod_ff;
         OP_SIN_6:     data3_in.s6 = prod_ff;
         OP_SIN_8:     data3_in.s8 = prod_ff;
         OP_POLY_1, OP_POLY_2, OP_POLY_3, OP_POLY_4:
                       data3_in.poly = data2_ff.poly + prod_ff;
         OP_SURFACE:   data3_in.surf  = prod_ff;
         OP_KCOEF:     data3_in.kcoef = K_LIN - prod_ff;
         OP_LINEAR:    data3_in.lin   = prod_ff;
         OP_HEIGHT_SQ: data3_in.hh    = prod_ff;
         OP_QUAD:      data3_in.grav  = data2_ff.err ? 44'd0 : g_rnd[43:0];
         default:      data3_in = data2_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (rdy3) data3_ff <= data3_in;
   end

endmodule
